>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define WBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Condition that must hold at every rising edge outside reset.
`define WBE_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant failed");

`endif

>>> rtl/wbe_pkg.sv
`default_nettype none
package wbe_pkg;

  localparam int MAX_WINDOW_DEF = 256;

  localparam int WL_W   = 9;
  localparam int EDGE_W = 16;
  localparam int DIFF_W = 32;
  localparam int SUM_W  = 40;
  localparam int ESUM_W = 42;
  localparam int ENT_W  = 14;
  localparam int MK_W   = 16;

  localparam logic [WL_W-1:0]   WL_RESET       = 9'd64;
  localparam logic [WL_W-1:0]   WL_MIN         = 9'd8;
  localparam logic [EDGE_W-1:0] EDGE_LOW_RESET = 16'd64;
  localparam logic [EDGE_W-1:0] EDGE_MID_RESET = 16'd128;
  localparam logic [EDGE_W-1:0] EDGE_HI_RESET  = 16'd256;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [ENT_W-1:0] ENT_CAP = 14'd8192;
  localparam logic [MK_W-1:0]  MK_CAP  = 16'd40960;

  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_EDGE_LOW = 2'd1;
  localparam logic [1:0] REG_EDGE_MID = 2'd2;
  localparam logic [1:0] REG_EDGE_HI  = 2'd3;

  typedef logic [SUM_W-1:0] sum_t;
  typedef sum_t [3:0] sums_t;

  function automatic logic [1:0] pick_band(input logic [DIFF_W-1:0] a,
                                           input logic [EDGE_W-1:0] lo,
                                           input logic [EDGE_W-1:0] mid,
                                           input logic [EDGE_W-1:0] hi);
    logic [1:0] b;
    if (a < {16'd0, lo}) b = 2'd0;
    else if (a < {16'd0, mid}) b = 2'd1;
    else if (a < {16'd0, hi}) b = 2'd2;
    else b = 2'd3;
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/wbe_entropy.sv
`default_nettype none
module wbe_entropy (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire wbe_pkg::sums_t     sums,
  output logic                    done,
  output logic [wbe_pkg::ENT_W-1:0] ent
);
  import wbe_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [9:0] {
    U_IDLE  = 10'b0000000001,
    U_NORM  = 10'b0000000010,
    U_DLOAD = 10'b0000000100,
    U_DIV   = 10'b0000001000,
    U_LNORM = 10'b0000010000,
    U_SQM   = 10'b0000100000,
    U_SQU   = 10'b0001000000,
    U_TERM  = 10'b0010000000,
    U_ACC   = 10'b0100000000,
    U_DONE  = 10'b1000000000
  } ustate_t;

  ustate_t          st_r;
  sums_t            s_r;
  logic [ESUM_W-1:0] e_r;
  logic [1:0]       k_r;
  logic [31:0]      rem_r;
  logic [30:0]      q_r;
  logic [4:0]       it_r;
  logic [30:0]      y_r;
  logic [4:0]       cnt_r;
  logic [15:0]      frac_r;
  logic [61:0]      sq_r;
  logic [51:0]      term_r;
  logic [51:0]      acc_r;

  logic [ESUM_W-1:0] e_sum;
  logic [32:0]      trial;
  logic             bit_in;
  logic [30:0]      q_nxt;
  logic [31:0]      sq_t;
  logic [20:0]      neglog;
  logic [52:0]      h_full;
  logic [18:0]      h_raw;

  assign e_sum = ESUM_W'(sums[0]) + ESUM_W'(sums[1]) + ESUM_W'(sums[2])
               + ESUM_W'(sums[3]);
  assign bit_in = (it_r == 5'd0) ? s_r[k_r][0] : 1'b0;
  assign trial  = {rem_r, bit_in};
  assign q_nxt  = (trial >= {1'b0, e_r[31:0]}) ? {q_r[29:0], 1'b1} : {q_r[29:0], 1'b0};
  assign sq_t   = sq_r[61:30];
  assign neglog = {cnt_r, 16'd0} - {5'd0, frac_r};
  assign h_full = {1'b0, acc_r} + 53'(64'd1 << 33);
  assign h_raw  = h_full[52:34];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= U_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        U_IDLE: begin
          if (start) begin
            s_r   <= sums;
            e_r   <= e_sum;
            acc_r <= '0;
            k_r   <= 2'd0;
            st_r  <= U_NORM;
          end
        end
        U_NORM: begin
          if (e_r == '0) begin
            st_r <= U_DONE;
          end else if (e_r[ESUM_W-1:32] != '0) begin
            e_r <= e_r >> 1;
            for (int i = 0; i < 4; i++) s_r[i] <= s_r[i] >> 1;
          end else begin
            st_r <= U_DLOAD;
          end
        end
        U_DLOAD: begin
          rem_r <= {1'b0, s_r[k_r][31:1]};
          q_r   <= '0;
          it_r  <= '0;
          st_r  <= U_DIV;
        end
        U_DIV: begin
          rem_r <= (trial >= {1'b0, e_r[31:0]}) ? 32'(trial - {1'b0, e_r[31:0]})
                                                : trial[31:0];
          q_r   <= q_nxt;
          it_r  <= it_r + 5'd1;
          if (it_r == 5'd30) begin
            y_r   <= q_nxt;
            cnt_r <= '0;
            if (q_nxt == '0) begin
              st_r <= (k_r == 2'd3) ? U_DONE : U_DLOAD;
              k_r  <= k_r + 2'd1;
            end else begin
              st_r <= U_LNORM;
            end
          end
        end
        U_LNORM: begin
          if (!y_r[30]) begin
            y_r   <= {y_r[29:0], 1'b0};
            cnt_r <= cnt_r + 5'd1;
          end else begin
            it_r   <= '0;
            frac_r <= '0;
            st_r   <= U_SQM;
          end
        end
        U_SQM: begin
          sq_r <= 62'(y_r) * 62'(y_r);
          st_r <= U_SQU;
        end
        U_SQU: begin
          frac_r <= {frac_r[14:0], sq_t[31]};
          y_r    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
          it_r   <= it_r + 5'd1;
          st_r   <= (it_r == 5'd15) ? U_TERM : U_SQM;
        end
        U_TERM: begin
          term_r <= 52'(q_r) * 52'(neglog);
          st_r   <= U_ACC;
        end
        U_ACC: begin
          acc_r <= acc_r + term_r;
          k_r   <= k_r + 2'd1;
          st_r  <= (k_r == 2'd3) ? U_DONE : U_DLOAD;
        end
        U_DONE: begin
          ent  <= (h_raw > 19'(ENT_CAP)) ? ENT_CAP : h_raw[ENT_W-1:0];
          done <= 1'b1;
          st_r <= U_IDLE;
        end
        default: st_r <= U_IDLE;
      endcase
    end
  end

  `WBE_ASSERT_IMP(a_start_idle, clk, rst_n, start, st_r == U_IDLE)
  `WBE_ASSERT_IMP(a_done_idle, clk, rst_n, done, st_r == U_IDLE)
  `WBE_ASSERT_ALWAYS(a_ent_cap, clk, rst_n, !done || ent <= ENT_CAP)

endmodule
`default_nettype wire

>>> rtl/windowed_band_entropy.sv
`default_nettype none
// An item before the third sample passes read, evict, add and the output
// register; every later item also waits for the shared divide / log unit (per
// band a 31-bit quotient, a normalize and 16 squarings).
// Throughput: one item at a time; the next is taken when the current result is
// in the output register. Synchronous active-low reset clears the state
// machines, pointers and band sums; the ring memory is not cleared.
module windowed_band_entropy #(
  parameter int MAX_WINDOW = wbe_pkg::MAX_WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] price_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [13:0] entropy_bits, [29:14] marker_size
  output logic [0:0]       out_tuser,  // [0] ready_res
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import wbe_pkg::*;
  `include "assert_macros.svh"

  localparam int PW = $clog2(MAX_WINDOW);
  localparam int NW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVICT = 7'b0000100,
    S_ADD   = 7'b0001000,
    S_START = 7'b0010000,
    S_CALC  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t            state_r;
  logic [WL_W-1:0]   wl_r;
  logic [EDGE_W-1:0] edge_lo_r, edge_mid_r, edge_hi_r;
  sums_t             sums_r;
  logic [31:0]       prev_r;
  logic [NW-1:0]     held_r;
  logic [NW-1:0]     ptr_r;
  logic [NW-1:0]     ptr_use_r;
  logic [1:0]        seen_r;
  logic [DIFF_W-1:0] a_r;
  logic              first_r;
  logic [ENT_W-1:0]  h_r;

  logic [DIFF_W-1:0] ring [MAX_WINDOW];
  logic [DIFF_W-1:0] rd_q;

  logic [NW-1:0]     n_eff;
  logic [32:0]       d;
  logic [32:0]       d_abs;
  logic [DIFF_W-1:0] a_new;
  logic [1:0]        ob, nb;
  logic [SUM_W:0]    add_sum;
  logic              u_start, u_done;
  logic [ENT_W-1:0]  u_ent;
  logic [16:0]       mk;

  always_comb begin
    if (wl_r < WL_MIN) n_eff = NW'(64);
    else if ({23'd0, wl_r} > 32'(MAX_WINDOW)) n_eff = NW'(MAX_WINDOW);
    else n_eff = NW'(wl_r);
  end

  assign d     = {in_tdata[31], in_tdata} - {prev_r[31], prev_r};
  assign d_abs = d[32] ? 33'(-d) : d;
  assign a_new = d_abs[32] ? '1 : d_abs[31:0];
  assign ob    = pick_band(rd_q, edge_lo_r, edge_mid_r, edge_hi_r);
  assign nb    = pick_band(a_r, edge_lo_r, edge_mid_r, edge_hi_r);
  assign add_sum = {1'b0, sums_r[nb]} + (SUM_W + 1)'(a_r);

  // config write takes priority over an item in the idle state
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign u_start   = (state_r == S_START);
  assign mk        = 17'(h_r) * 17'd5;

  always_ff @(posedge clk) begin
    rd_q <= ring[ptr_use_r[PW-1:0]];
    if (state_r == S_ADD && !first_r) ring[ptr_use_r[PW-1:0]] <= a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wl_r       <= WL_RESET;
      edge_lo_r  <= EDGE_LOW_RESET;
      edge_mid_r <= EDGE_MID_RESET;
      edge_hi_r  <= EDGE_HI_RESET;
      sums_r     <= '0;
      prev_r     <= '0;
      held_r     <= '0;
      ptr_r      <= '0;
      ptr_use_r  <= '0;
      seen_r     <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              8'(REG_WINDOW): begin
                wl_r   <= cfg_data[WL_W-1:0];
                sums_r <= '0;
                held_r <= '0;
                ptr_r  <= '0;
              end
              8'(REG_EDGE_LOW): edge_lo_r  <= cfg_data;
              8'(REG_EDGE_MID): edge_mid_r <= cfg_data;
              8'(REG_EDGE_HI):  edge_hi_r  <= cfg_data;
              default: ;
            endcase
          end else if (in_tvalid) begin
            a_r       <= a_new;
            first_r   <= (seen_r == 2'd0);
            prev_r    <= in_tdata;
            seen_r    <= (seen_r == 2'd3) ? seen_r : seen_r + 2'd1;
            ptr_use_r <= (ptr_r >= n_eff) ? '0 : ptr_r;
            state_r   <= S_READ;
          end
        end
        S_READ: state_r <= S_EVICT;
        S_EVICT: begin
          if (!first_r) begin
            if (held_r >= n_eff) begin
              sums_r[ob] <= (sums_r[ob] > SUM_W'(rd_q)) ? sums_r[ob] - SUM_W'(rd_q) : '0;
            end else begin
              held_r <= held_r + NW'(1);
            end
          end
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (!first_r) begin
            ptr_r      <= (ptr_use_r + NW'(1) >= n_eff) ? '0 : ptr_use_r + NW'(1);
            sums_r[nb] <= add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
          end
          h_r     <= '0;
          state_r <= (seen_r == 2'd3) ? S_START : S_OUT;
        end
        S_START: state_r <= S_CALC;
        S_CALC: begin
          if (u_done) begin
            h_r     <= u_ent;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            out_tdata  <= {2'b00, (mk > 17'(MK_CAP)) ? MK_CAP : mk[MK_W-1:0], h_r};
            out_tuser  <= (seen_r == 2'd3);
            out_tvalid <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  wbe_entropy u_ent_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .sums  (sums_r),
    .done  (u_done),
    .ent   (u_ent)
  );

  `WBE_ASSERT_ALWAYS(a_held_le_n, clk, rst_n, held_r <= n_eff)
  `WBE_ASSERT_ALWAYS(a_ptr_lt_n, clk, rst_n, ptr_r < n_eff)
  `WBE_ASSERT_IMP(a_not_ready_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0)

endmodule
`default_nettype wire
